// File: sv/rgbc_color_temperature_ir_removed_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RGBC colour temperature block
// Shared property forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RGBC_COLOR_TEMPERATURE_IR_REMOVED_DEFINES_SVH
`define RGBC_COLOR_TEMPERATURE_IR_REMOVED_DEFINES_SVH

// same-cycle implication
`define RGBCCT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RGBCCT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/rgbcct_pkg.sv
// ----------------------------------------------------------------------------
// rgbcct_pkg
// Types and constants shared by the colour temperature datapath.
// ----------------------------------------------------------------------------
package rgbcct_pkg;

   localparam int unsigned CNT_W       = 16;
   localparam int unsigned SLOPE_W     = 12;
   localparam int unsigned DQ_W        = CNT_W + SLOPE_W;
   localparam int unsigned STEPS       = DQ_W;

   localparam logic [SLOPE_W-1:0] CCT_SLOPE   = 12'd3810;
   localparam logic [CNT_W-1:0]   CCT_OFFSET  = 16'd1391;
   localparam logic [CNT_W-1:0]   DIGITAL_SAT = 16'hFFFF;
   localparam logic [8:0]         ANALOG_LIMIT = 9'd63;
   localparam logic [7:0]         ATIME_RESET = 8'd255;

   typedef struct packed {
      logic             kill;
      logic [CNT_W-1:0] divisor;
      logic [CNT_W-1:0] rem;
      logic [DQ_W-1:0]  dq;
   } div_word_type;

   function automatic logic [CNT_W-1:0] sat_level(input logic [7:0] atime);
      logic [8:0]  cycles;
      logic [17:0] level;
      cycles = 9'd256 - {1'b0, atime};
      level  = ({9'd0, cycles} << 9) + ({9'd0, cycles} << 8);
      if (cycles > ANALOG_LIMIT) begin
         return DIGITAL_SAT;
      end
      return level[CNT_W-1:0];
   endfunction

endpackage

// File: sv/rgbc_color_temperature_ir_removed.sv
// ----------------------------------------------------------------------------
// rgbc_color_temperature_ir_removed
// Pipeline from req accept to rsp valid: 2 prep stages, 28 divider cells and
// 1 output register. Throughput: one item per cycle, set by the one-bit-per-cell
// restoring divider chain; each stage stalls only when full.
// Reset: synchronous; clears all valid bits, saturation level as for atime 255.
// ----------------------------------------------------------------------------
module rgbc_color_temperature_ir_removed (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [7:0]                   csr_atime,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [rgbcct_pkg::CNT_W-1:0] req_red,
   input  logic [rgbcct_pkg::CNT_W-1:0] req_green,
   input  logic [rgbcct_pkg::CNT_W-1:0] req_blue,
   input  logic [rgbcct_pkg::CNT_W-1:0] req_clear,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rgbcct_pkg::CNT_W-1:0] rsp_kelvin
);
   import rgbcct_pkg::*;

   logic [CNT_W-1:0] sat_ff, sat_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] rsp_kelvin_ff, rsp_kelvin_in;
   logic             out_load;

   logic         chain_valid [0:STEPS];
   logic         chain_ready [0:STEPS];
   div_word_type chain_word  [0:STEPS];

   assign csr_ready = 1'b1;
   assign sat_in    = sat_level(csr_atime);

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff <= sat_level(ATIME_RESET);
      end else if (csr_valid) begin
         sat_ff <= sat_in;
      end
   end

   rgbcct_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .sat_level (sat_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_red    (req_red),
      .in_green  (req_green),
      .in_blue   (req_blue),
      .in_clear  (req_clear),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_word  (chain_word[0])
   );

   for (genvar i = 0; i < STEPS; i++) begin : g_cell
      rgbcct_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_word   (chain_word[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_word  (chain_word[i+1])
      );
   end

   assign chain_ready[STEPS] = !rsp_valid_ff || rsp_ready;
   assign out_load           = chain_ready[STEPS] && chain_valid[STEPS];

   always_comb begin
      rsp_kelvin_in = chain_word[STEPS].kill ? '0
                    : chain_word[STEPS].dq[CNT_W-1:0] + CCT_OFFSET;
      rsp_valid_in  = chain_ready[STEPS] ? chain_valid[STEPS] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kelvin_ff <= rsp_kelvin_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_kelvin = rsp_kelvin_ff;

endmodule

// File: sv/rgbcct_prep.sv
// ----------------------------------------------------------------------------
// rgbcct_prep
// Two-stage front end: IR removal and validity check, then slope multiply.
// ----------------------------------------------------------------------------
module rgbcct_prep (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rgbcct_pkg::CNT_W-1:0] sat_level,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [rgbcct_pkg::CNT_W-1:0] in_red,
   input  logic [rgbcct_pkg::CNT_W-1:0] in_green,
   input  logic [rgbcct_pkg::CNT_W-1:0] in_blue,
   input  logic [rgbcct_pkg::CNT_W-1:0] in_clear,
   output logic                        out_valid,
   input  logic                        out_ready,
   output rgbcct_pkg::div_word_type    out_word
);
   import rgbcct_pkg::*;

   logic             v1_ff, v1_in;
   logic             kill1_ff, kill1_in;
   logic [CNT_W-1:0] r2_ff, r2_in;
   logic [CNT_W-1:0] b2_ff, b2_in;
   logic             v2_ff, v2_in;
   div_word_type     word2_ff, word2_in;

   logic             s1_ready;
   logic             s2_ready;
   logic [CNT_W+1:0] sum;
   logic [CNT_W+1:0] excess;
   logic [CNT_W-1:0] ir;
   logic [DQ_W-1:0]  product;

   assign s2_ready = !v2_ff || out_ready;
   assign s1_ready = !v1_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      sum    = {2'b00, in_red} + {2'b00, in_green} + {2'b00, in_blue};
      excess = sum - {2'b00, in_clear};
      ir     = (sum > {2'b00, in_clear}) ? excess[CNT_W:1] : '0;
      r2_in  = in_red - ir;
      b2_in  = in_blue - ir;
      kill1_in = (in_clear == '0) || (in_clear >= sat_level);
      v1_in  = s1_ready ? in_valid : v1_ff;
   end

   always_comb begin
      product          = DQ_W'(CCT_SLOPE) * DQ_W'(b2_ff);
      word2_in.kill    = kill1_ff || (r2_ff == '0);
      word2_in.divisor = r2_ff;
      word2_in.rem     = '0;
      word2_in.dq      = product;
      v2_in            = s2_ready ? v1_ff : v2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         kill1_ff <= kill1_in;
         r2_ff    <= r2_in;
         b2_ff    <= b2_in;
      end
      if (s2_ready && v1_ff) begin
         word2_ff <= word2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_word  = word2_ff;

endmodule

// File: sv/rgbcct_div_cell.sv
// ----------------------------------------------------------------------------
// rgbcct_div_cell
// One restoring division step: shifts in a dividend bit, yields a quotient bit.
// ----------------------------------------------------------------------------
`include "rgbc_color_temperature_ir_removed_defines.svh"

module rgbcct_div_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  rgbcct_pkg::div_word_type in_word,
   output logic                     out_valid,
   input  logic                     out_ready,
   output rgbcct_pkg::div_word_type out_word
);
   import rgbcct_pkg::*;

   logic         valid_ff, valid_in;
   div_word_type word_ff, word_in;
   logic [CNT_W:0] trial;
   logic [CNT_W:0] diff;
   logic           fits;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      trial = {in_word.rem, in_word.dq[DQ_W-1]};
      diff  = trial - {1'b0, in_word.divisor};
      fits  = trial >= {1'b0, in_word.divisor};
      word_in.kill    = in_word.kill;
      word_in.divisor = in_word.divisor;
      word_in.rem     = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      word_in.dq      = {in_word.dq[DQ_W-2:0], fits};
      valid_in        = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   `RGBCCT_ASSERT_NOW(a_rem_below_divisor, valid_ff && (word_ff.divisor != '0),
      word_ff.rem < word_ff.divisor, "partial remainder not below divisor")
   `RGBCCT_ASSERT_NEXT(a_hold_on_stall, valid_ff && !out_ready,
      valid_ff && $stable(word_ff), "cell item changed while stalled")
   `RGBCCT_ASSERT_NEXT(a_drain, valid_ff && out_ready && !in_valid,
      !valid_ff, "cell kept an item after handing it on")

endmodule
